@@ hdl/hotb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hotb_pkg
// Types, codes and character helpers for the hex/binary text-to-bytes block.
// ----------------------------------------------------------------------------
package hotb_pkg;

    localparam int unsigned POS_W = 32;

    localparam logic [7:0] CH_HASH = 8'h23;  // '#'
    localparam logic [7:0] CH_X    = 8'h78;  // 'x'
    localparam logic [7:0] CH_B    = 8'h62;  // 'b'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE  = 8'h31;  // '1'
    localparam logic [3:0] NIB_A   = 4'hA;
    localparam logic [3:0] NIB_F   = 4'hF;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [1:0] ERR_END_DIRECTIVE = 2'd0;
    localparam logic [1:0] ERR_END_IN_BYTE   = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX       = 2'd2;
    localparam logic [1:0] ERR_BAD_BIN       = 2'd3;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic [1:0]       error_code;
        logic [POS_W-1:0] char_position;
    } out_item_t;

    typedef struct packed {
        logic             binary_mode;
        logic             directive_pending;
        logic             in_byte;
        logic [2:0]       digits_taken;
        logic [7:0]       partial_byte;
        logic [POS_W-1:0] char_count;
        logic             halted;
    } conv_state_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // 'a'..'f' and 'A'..'F' share low bits 1..6
            r = {1'b1, NIB_A + c[3:0] - 4'd1};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage : hotb_pkg
`default_nettype wire

@@ hdl/hotb_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hotb_step
// Next-state and result logic for one character of text.
// ----------------------------------------------------------------------------
module hotb_step (
    input  wire hotb_pkg::conv_state_t st,
    input  wire hotb_pkg::in_item_t    item,
    output hotb_pkg::conv_state_t      st_next,
    output logic                       res_valid,
    output hotb_pkg::out_item_t        res
);
    import hotb_pkg::*;

    logic [7:0]       c;
    logic             last;
    logic [4:0]       hx;
    logic             do_digit;
    logic             err;
    logic [1:0]       err_code;
    logic             done;
    logic [7:0]       pb_base;
    logic [2:0]       dt_base;
    logic [7:0]       pb_new;
    logic [2:0]       dt_new;
    logic             bad;

    always_comb begin
        c        = item.text_char;
        last     = item.end_of_text;
        hx       = hex_decode(c);
        st_next  = st;
        res_valid = 1'b0;
        res      = '0;
        do_digit = 1'b0;
        err      = 1'b0;
        err_code = ERR_END_DIRECTIVE;
        done     = 1'b0;
        pb_base  = st.partial_byte;
        dt_base  = st.digits_taken;
        pb_new   = st.partial_byte;
        dt_new   = st.digits_taken;
        bad      = 1'b0;

        if (!st.halted) begin
            if (st.char_count != {POS_W{1'b1}}) begin
                st_next.char_count = st.char_count + 1'b1;
            end

            if (st.directive_pending) begin
                if (c == CH_X) begin
                    st_next.binary_mode = 1'b0;
                end else if (c == CH_B) begin
                    st_next.binary_mode = 1'b1;
                end
                st_next.directive_pending = 1'b0;
            end else if (!st.in_byte) begin
                if (c == CH_HASH) begin
                    if (last) begin
                        err      = 1'b1;
                        err_code = ERR_END_DIRECTIVE;
                    end else begin
                        st_next.directive_pending = 1'b1;
                    end
                end else if (hx[4]) begin
                    do_digit = 1'b1;
                    pb_base  = 8'd0;
                    dt_base  = 3'd0;
                end
            end else if (is_space(c)) begin
                if (last) begin
                    err      = 1'b1;
                    err_code = ERR_END_IN_BYTE;
                end
            end else begin
                do_digit = 1'b1;
            end

            if (do_digit) begin
                if (st.binary_mode) begin
                    bad    = (c != CH_ZERO) && (c != CH_ONE);
                    pb_new = pb_base | ((c == CH_ONE) ? (8'h80 >> dt_base) : 8'h00);
                    dt_new = dt_base + 3'd1;
                    done   = (dt_new == 3'd0);
                end else begin
                    bad = !hx[4];
                    if (!dt_base[0]) begin
                        pb_new = pb_base | {hx[3:0], 4'h0};
                        dt_new = 3'd1;
                    end else begin
                        pb_new = pb_base | {4'h0, hx[3:0]};
                        done   = 1'b1;
                    end
                end

                if (bad) begin
                    err      = 1'b1;
                    err_code = st.binary_mode ? ERR_BAD_BIN : ERR_BAD_HEX;
                end else if (done) begin
                    res_valid             = 1'b1;
                    res.kind              = KIND_DATA;
                    res.data_byte         = pb_new;
                    st_next.in_byte       = 1'b0;
                    st_next.digits_taken  = 3'd0;
                    st_next.partial_byte  = 8'd0;
                end else if (last) begin
                    err      = 1'b1;
                    err_code = ERR_END_IN_BYTE;
                end else begin
                    st_next.in_byte      = 1'b1;
                    st_next.digits_taken = dt_new;
                    st_next.partial_byte = pb_new;
                end
            end

            if (err) begin
                res_valid                 = 1'b1;
                res.kind                  = KIND_ERROR;
                res.data_byte             = 8'd0;
                res.error_code            = err_code;
                res.char_position         = st.char_count;
                st_next.halted            = 1'b1;
                st_next.directive_pending = 1'b0;
                st_next.in_byte           = 1'b0;
                st_next.digits_taken      = 3'd0;
                st_next.partial_byte      = 8'd0;
            end
        end
    end

endmodule : hotb_step
`default_nettype wire

@@ hdl/hex_or_binary_text_to_bytes_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hex_or_binary_text_to_bytes_top
// Turns a stream of hex or binary digit text into raw bytes and error reports.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid register when
// the output is stalled. Throughput: one character per cycle while the skid register
// is empty; s_ready drops while a result waits in the skid stage.
// Reset (aresetn low, synchronous): hex mode, no open byte, position 0, not halted.
// ----------------------------------------------------------------------------
module hex_or_binary_text_to_bytes_top (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire                  cfg_wr_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire hotb_pkg::in_item_t s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output hotb_pkg::out_item_t  m_data
);
    import hotb_pkg::*;

    conv_state_t st_reg, st_next, st_step;
    logic        res_valid;
    out_item_t   res;
    logic        accept;
    logic        res_push;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_data_reg, skid_data_next;

    hotb_step u_step (
        .st        (st_reg),
        .item      (s_data),
        .st_next   (st_step),
        .res_valid (res_valid),
        .res       (res)
    );

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign res_push = accept && res_valid;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        st_next = accept ? st_step : st_reg;
        // mode write also selects the current mode
        if (cfg_wr_en) begin
            st_next.binary_mode = cfg_wr_data;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_push;
                out_data_next  = res;
            end
        end else if (res_push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            st_reg         <= st_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule : hex_or_binary_text_to_bytes_top
`default_nettype wire

@@ bench/hex_or_binary_text_to_bytes_top_tb.sv @@
// ----------------------------------------------------------------------------
// hex_or_binary_text_to_bytes_top_tb
// Drives character text into the hex/binary converter with random gaps on both
// sides. A behavioral predictor works out every byte and error report, and a
// monitor compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module hex_or_binary_text_to_bytes_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hotb_pkg::*;

    typedef enum int {
        HALT_END_AFTER_HASH,
        HALT_END_ON_BLANK,
        HALT_END_ON_DIGIT,
        HALT_HASH_IN_BYTE,
        HALT_BINARY_START,
        HALT_BAD_BIN_AT_END,
        HALT_BAD_HEX_AT_END
    } halt_case_t;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_item_t m_data;

    conv_state_t conv_model;
    out_item_t   bytes_and_errors_due[$];
    int          mismatches = 0;
    bit          src_calm   = 1'b0;
    bit          sink_calm  = 1'b0;

    hex_or_binary_text_to_bytes_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= "9") return c - CH_ZERO;
        if (c >= "a" && c <= "f") return c - "a" + NIB_A;
        if (c >= "A" && c <= "F") return c - "A" + NIB_A;
        return -1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit report_error(inout conv_state_t st, output out_item_t res,
                                        input logic [1:0] code, input logic [POS_W-1:0] pos);
        res = '0;
        res.kind = KIND_ERROR;
        res.error_code = code;
        res.char_position = pos;
        st.halted = 1'b1;
        st.directive_pending = 1'b0;
        st.in_byte = 1'b0;
        st.digits_taken = '0;
        st.partial_byte = '0;
        return 1'b1;
    endfunction

    function automatic bit finish_byte(inout conv_state_t st, output out_item_t res);
        res = '0;
        res.kind = KIND_DATA;
        res.data_byte = st.partial_byte;
        st.in_byte = 1'b0;
        st.digits_taken = '0;
        st.partial_byte = '0;
        return 1'b1;
    endfunction

    // Returns 1 when the character produces a byte or an error report.
    function automatic bit convert_char(inout conv_state_t st, input in_item_t it,
                                        output out_item_t res);
        logic [POS_W-1:0] pos;
        int               nib;
        res = '0;
        if (st.halted) return 1'b0;
        pos = st.char_count;
        if (st.char_count != '1) st.char_count++;

        if (st.directive_pending) begin
            if (it.text_char == CH_X) st.binary_mode = 1'b0;
            else if (it.text_char == CH_B) st.binary_mode = 1'b1;
            st.directive_pending = 1'b0;
            return 1'b0;
        end

        nib = nibble_of(it.text_char);
        if (!st.in_byte) begin
            if (it.text_char == CH_HASH) begin
                if (it.end_of_text) return report_error(st, res, ERR_END_DIRECTIVE, pos);
                st.directive_pending = 1'b1;
                return 1'b0;
            end
            if (nib < 0) return 1'b0;
            st.in_byte = 1'b1;
            st.digits_taken = '0;
            st.partial_byte = '0;
        end else if (is_blank(it.text_char)) begin
            if (it.end_of_text) return report_error(st, res, ERR_END_IN_BYTE, pos);
            return 1'b0;
        end

        if (st.binary_mode) begin
            if (it.text_char != CH_ZERO && it.text_char != CH_ONE)
                return report_error(st, res, ERR_BAD_BIN, pos);
            if (it.text_char == CH_ONE) st.partial_byte[3'd7 - st.digits_taken] = 1'b1;
            st.digits_taken = st.digits_taken + 3'd1;
            if (st.digits_taken == 3'd0) return finish_byte(st, res);
        end else begin
            if (nib < 0) return report_error(st, res, ERR_BAD_HEX, pos);
            // odd digit count (possibly left over from binary) means low nibble
            if (!st.digits_taken[0]) begin
                st.partial_byte[7:4] = st.partial_byte[7:4] | nib[3:0];
                st.digits_taken = 3'd1;
            end else begin
                st.partial_byte[3:0] = st.partial_byte[3:0] | nib[3:0];
                return finish_byte(st, res);
            end
        end
        if (it.end_of_text) return report_error(st, res, ERR_END_IN_BYTE, pos);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t mk_item(input logic [7:0] c, input logic eot);
        in_item_t it;
        it.text_char = c;
        it.end_of_text = eot;
        return it;
    endfunction

    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        int unsigned w;
        w = $urandom_range(8, 13);
        return (w == 8) ? 8'(" ") : 8'(w);
    endfunction

    function automatic logic [7:0] mode_digit();
        if (conv_model.binary_mode) return $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
        return hex_char();
    endfunction

    // Mostly well-formed text for the current state; anything that would
    // halt the block is redrawn, since reset happens only once.
    function automatic in_item_t pick_text_char();
        in_item_t    cand;
        conv_state_t trial;
        out_item_t   res;
        int unsigned roll;
        for (int tries = 0; tries < 8; tries++) begin
            roll = $urandom_range(0, 99);
            cand.end_of_text = ($urandom_range(0, 11) == 0);
            if (roll < 8) begin
                cand.text_char = 8'($urandom_range(0, 255));
                cand.end_of_text = 1'($urandom_range(0, 1));
            end else if (conv_model.directive_pending) begin
                cand.text_char = (roll < 45) ? CH_X :
                                 (roll < 80) ? CH_B : 8'($urandom_range(0, 255));
            end else if (conv_model.in_byte) begin
                cand.text_char = (roll < 85) ? mode_digit() : blank_char();
            end else if (roll < 60) begin
                cand.text_char = mode_digit();
            end else if (roll < 75) begin
                cand.text_char = 8'($urandom_range(0, 255));
            end else if (roll < 90) begin
                cand.text_char = blank_char();
            end else begin
                cand.text_char = CH_HASH;
            end
            trial = conv_model;
            if (!(convert_char(trial, cand, res) && res.kind == KIND_ERROR)) return cand;
        end
        return mk_item(CH_ZERO, 1'b0);
    endfunction

    task automatic send_text_char(input in_item_t it);
        int unsigned gap;
        out_item_t   res;
        gap = draw_gap(src_calm);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (convert_char(conv_model, it, res)) bytes_and_errors_due.push_back(res);
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++) send_text_char(mk_item(s[i], 1'b0));
    endtask

    // Drop valid, let every prediction arrive, then give the pipeline time
    // to finish characters that produce nothing.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (bytes_and_errors_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        conv_model.binary_mode = mode;
    endtask

    // Close any open byte or directive without changing the mode.
    task automatic settle_text();
        while (conv_model.in_byte || conv_model.directive_pending)
            send_text_char(mk_item(CH_ZERO, 1'b0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_chars("00");
        send_chars("Ff");
        send_text_char(mk_item(8'h00, 1'b0));
        send_text_char(mk_item(8'hFF, 1'b1));   // end of text outside a byte
        send_chars("a 5");                      // blank inside a byte
        send_chars("#");
        send_text_char(mk_item(CH_B, 1'b1));    // end on the directive itself
        send_chars("10110011");
        send_chars("#x#q");                     // unknown directive is consumed
        send_chars("9");
        send_text_char(mk_item("E", 1'b1));
    endtask

    task automatic test_mode_switch_mid_byte();
        write_mode(1'b0);
        send_chars("c");
        write_mode(1'b1);
        send_chars("0110101");
        send_chars("1");
        write_mode(1'b0);
        send_chars("d");
    endtask

    task automatic test_random_text(input logic mode, input int unsigned count);
        write_mode(mode);
        repeat (count) send_text_char(pick_text_char());
    endtask

    // One error per run; afterwards the block must stay silent.
    task automatic test_error_halt();
        halt_case_t hc;
        hc = halt_case_t'($urandom_range(0, 6));
        case (hc)
            HALT_END_AFTER_HASH: begin
                settle_text();
                send_text_char(mk_item(CH_HASH, 1'b1));
            end
            HALT_END_ON_BLANK: begin
                write_mode(1'b0);
                settle_text();
                send_chars("a");
                send_text_char(mk_item(" ", 1'b1));
            end
            HALT_END_ON_DIGIT: begin
                write_mode(1'b1);
                settle_text();
                send_chars("10");
                send_text_char(mk_item(CH_ONE, 1'b1));
            end
            HALT_HASH_IN_BYTE: begin
                write_mode(1'b0);
                settle_text();
                send_chars("4#");
            end
            HALT_BINARY_START: begin
                write_mode(1'b1);
                settle_text();
                send_chars("7");
            end
            HALT_BAD_BIN_AT_END: begin
                write_mode(1'b1);
                settle_text();
                send_chars("1");
                send_text_char(mk_item("2", 1'b1));
            end
            default: begin
                write_mode(1'b0);
                settle_text();
                send_chars("c");
                send_text_char(mk_item("g", 1'b1));
            end
        endcase
        repeat (12)
            send_text_char(mk_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and checking
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            gap = draw_gap(sink_calm);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (bytes_and_errors_due.size() == 0) begin
                $display("%0t ns: extra transfer, expected none, actual %0d/0x%0h/%0d/%0d",
                         $time, m_data.kind, m_data.data_byte, m_data.error_code,
                         m_data.char_position);
                mismatches++;
            end else begin
                want = bytes_and_errors_due.pop_front();
                if (m_data.kind !== want.kind)
                    report_field("kind", 32'(want.kind), 32'(m_data.kind));
                if (m_data.data_byte !== want.data_byte)
                    report_field("data_byte", 32'(want.data_byte), 32'(m_data.data_byte));
                if (m_data.error_code !== want.error_code)
                    report_field("error_code", 32'(want.error_code), 32'(m_data.error_code));
                if (m_data.char_position !== want.char_position)
                    report_field("char_position", want.char_position, m_data.char_position);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        conv_model = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_mode_switch_mid_byte();
        test_random_text(1'b1, 260);
        test_random_text(1'b0, 260);
        test_random_text(1'($urandom_range(0, 1)), 260);
        test_random_text(1'b1, 260);
        test_error_halt();

        s_valid <= 1'b0;
        for (int guard = 0; guard < 2000 && bytes_and_errors_due.size() != 0; guard++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (bytes_and_errors_due.size() != 0) begin
            $display("%0t ns: %0d predicted results never arrived", $time,
                     bytes_and_errors_due.size());
            mismatches += bytes_and_errors_due.size();
        end
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #500_000;
        $display("timeout waiting for transfers");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
